// File: hdl/taf_pkg.sv
// Package of shared types, codes and the sine table builder for the triangle transform.
package taf_pkg;

   // Transform mode codes held in the mode register.
   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_SCALE     = 2'd1;
   localparam logic [1:0] MODE_ROTATE    = 2'd2;

   // Register indexes of the configuration channel.
   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_PARAM_X   = 2'd1;
   localparam logic [1:0] CSR_PARAM_Y   = 2'd2;
   localparam logic [1:0] CSR_ANGLE_DEG = 2'd3;

   localparam int COORD_W   = 12;
   localparam int RESULT_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam int ANGLE_W   = 9;
   localparam int SIN_ENTRIES = 91;
   localparam int SIN_IDX_W   = 7;

   // Pi in Q4.60 and one degree in the same format.
   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_STEP = PI_Q60 / 64'd180;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by_coord;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } taf_tri_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] out_ax;
      logic signed [RESULT_W-1:0] out_ay;
      logic signed [RESULT_W-1:0] out_bx;
      logic signed [RESULT_W-1:0] out_by;
      logic signed [RESULT_W-1:0] out_cx;
      logic signed [RESULT_W-1:0] out_cy;
   } taf_res_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0]                mode;
      logic signed [COORD_W-1:0] param_x;
      logic signed [COORD_W-1:0] param_y;
   } taf_cfg_type;

   // Sine of k degrees in unsigned Q2.30 by an eleven-term Taylor series.
   // Evaluated at elaboration only, to build the constant table.
   function automatic logic [63:0] sin_q30(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (64'(k) * DEG_STEP + (64'd1 << 29)) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n < 11; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            7:       term = term / 64'd210;
            8:       term = term / 64'd272;
            9:       term = term / 64'd342;
            default: term = term / 64'd420;
         endcase
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

endpackage

// File: hdl/taf_channels.sv
// Handshake channel interfaces for requests, results and register writes.
interface taf_req_if;
   import taf_pkg::*;
   logic        valid;
   logic        ready;
   taf_tri_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface taf_rsp_if;
   import taf_pkg::*;
   logic        valid;
   logic        ready;
   taf_res_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface taf_csr_if;
   import taf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/taf_csr_regs.sv
// Configuration registers and the sine and cosine lookup for the rotation angle.
module taf_csr_regs #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   taf_csr_if.sink                       csr_ch,
   output taf_pkg::taf_cfg_type          cfg,
   output logic signed [TRIG_FRAC_BITS+1:0] trig_sin,
   output logic signed [TRIG_FRAC_BITS+1:0] trig_cos
);
   import taf_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;

   logic [1:0]                mode_ff;
   logic signed [COORD_W-1:0] param_x_ff;
   logic signed [COORD_W-1:0] param_y_ff;
   logic [ANGLE_W-1:0]        angle_ff;
   logic                      wr_en;

   logic signed [TW-1:0] sin_rom [SIN_ENTRIES];
   logic [ANGLE_W-1:0]   ang_red;
   logic [ANGLE_W-1:0]   ang_cos;
   logic [SIN_IDX_W:0]   sin_sel;
   logic [SIN_IDX_W:0]   cos_sel;

   // Writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_TRANSLATE;
         param_x_ff <= '0;
         param_y_ff <= '0;
         angle_ff   <= '0;
      end else if (wr_en) begin
         case (csr_ch.index)
            CSR_MODE:      mode_ff    <= csr_ch.data[1:0];
            CSR_PARAM_X:   param_x_ff <= csr_ch.data[COORD_W-1:0];
            CSR_PARAM_Y:   param_y_ff <= csr_ch.data[COORD_W-1:0];
            CSR_ANGLE_DEG: angle_ff   <= csr_ch.data[ANGLE_W-1:0];
            default:       mode_ff    <= mode_ff;
         endcase
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.param_x = param_x_ff;
   assign cfg.param_y = param_y_ff;

   // Quarter-wave sine table, rounded half up from Q2.30 to the chosen fraction.
   for (genvar k = 0; k < SIN_ENTRIES; k++) begin : g_rom
      localparam logic [63:0] SIN_Q30 = sin_q30(k);
      localparam logic [63:0] SIN_RND =
         (SIN_Q30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      assign sin_rom[k] = SIN_RND[TW-1:0];
   end

   // Fold an angle of 0 to 359 degrees onto the quarter table; the top bit flags negation.
   function automatic logic [SIN_IDX_W:0] fold_angle(input logic [ANGLE_W-1:0] a);
      logic [ANGLE_W-1:0] t;
      logic               neg;
      if (a <= ANGLE_W'(90)) begin
         t   = a;
         neg = 1'b0;
      end else if (a <= ANGLE_W'(180)) begin
         t   = ANGLE_W'(180) - a;
         neg = 1'b0;
      end else if (a <= ANGLE_W'(270)) begin
         t   = a - ANGLE_W'(180);
         neg = 1'b1;
      end else begin
         t   = ANGLE_W'(360) - a;
         neg = 1'b1;
      end
      return {neg, t[SIN_IDX_W-1:0]};
   endfunction

   // Reduce the angle into one turn and derive the cosine angle a quarter turn on.
   always_comb begin
      ang_red = (angle_ff >= ANGLE_W'(360)) ? angle_ff - ANGLE_W'(360) : angle_ff;
      ang_cos = (ang_red >= ANGLE_W'(270)) ? ang_red - ANGLE_W'(270)
                                           : ang_red + ANGLE_W'(90);
      sin_sel = fold_angle(ang_red);
      cos_sel = fold_angle(ang_cos);
   end

   assign trig_sin = sin_sel[SIN_IDX_W] ? -sin_rom[sin_sel[SIN_IDX_W-1:0]]
                                        :  sin_rom[sin_sel[SIN_IDX_W-1:0]];
   assign trig_cos = cos_sel[SIN_IDX_W] ? -sin_rom[cos_sel[SIN_IDX_W-1:0]]
                                        :  sin_rom[cos_sel[SIN_IDX_W-1:0]];

`ifndef SYNTHESIS
   // The magnitude of sine and cosine never exceeds one.
   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      (trig_sin <= TW'(1 << TRIG_FRAC_BITS)) && (trig_sin >= -TW'(1 << TRIG_FRAC_BITS)))
      else $error("sine out of range");
   // At an angle of zero the cosine is exactly one and the sine is zero.
   a_cos_zero: assert property (@(posedge clock) disable iff (reset)
      (angle_ff == '0) |-> (trig_cos == TW'(1 << TRIG_FRAC_BITS) && trig_sin == '0))
      else $error("zero angle trig mismatch");
   // A mode write lands in the mode register.
   a_mode_wr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && csr_ch.index == CSR_MODE) |=> (mode_ff == $past(csr_ch.data[1:0])))
      else $error("mode write lost");
`endif

endmodule

// File: hdl/taf_xform.sv
// Two-register transform pipeline: request register, vertex arithmetic, result register.
module taf_xform #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   taf_req_if.sink                          req_ch,
   taf_rsp_if.source                        rsp_ch,
   input  taf_pkg::taf_cfg_type             cfg,
   input  logic signed [TRIG_FRAC_BITS+1:0] trig_sin,
   input  logic signed [TRIG_FRAC_BITS+1:0] trig_cos
);
   import taf_pkg::*;

   localparam int TW  = TRIG_FRAC_BITS + 2;
   localparam int PW  = TW + COORD_W + 2;
   localparam int WW  = 2 * COORD_W + 1;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   taf_tri_type s1_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   taf_res_type rsp_data_ff;
   taf_res_type rsp_data_in;
   logic        s1_take;
   logic        s2_load;

   // Handshake: the request register drains into the result register whenever
   // that register is empty or being read in the same cycle.
   assign s2_load      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign s1_take      = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in  = s1_take ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_data_ff <= req_ch.data;
      end
      if (s2_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Clamp a wide signed value to the 16-bit result range.
   function automatic logic signed [RESULT_W-1:0] sat16(input logic signed [WW-1:0] v);
      logic signed [RESULT_W-1:0] r;
      if (v > WW'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -WW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[RESULT_W-1:0];
      end
      return r;
   endfunction

   // Fixed-point product sum shifted down with truncation toward zero.
   function automatic logic signed [RESULT_W-1:0] trunc_frac(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] bias;
      logic signed [PW-1:0] q;
      bias = v[PW-1] ? PW'((1 << TRIG_FRAC_BITS) - 1) : '0;
      q    = (v + bias) >>> TRIG_FRAC_BITS;
      return q[RESULT_W-1:0];
   endfunction

   // One vertex through the selected transform; returns {x, y}.
   function automatic logic [2*RESULT_W-1:0] vertex(
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] px_pivot,
      input logic signed [COORD_W-1:0] py_pivot
   );
      logic signed [COORD_W:0]    dx;
      logic signed [COORD_W:0]    dy;
      logic signed [PW-1:0]       rot_x;
      logic signed [PW-1:0]       rot_y;
      logic signed [RESULT_W-1:0] qx;
      logic signed [RESULT_W-1:0] qy;
      logic signed [WW-1:0]       wx;
      logic signed [WW-1:0]       wy;
      dx    = {x[COORD_W-1], x} - {px_pivot[COORD_W-1], px_pivot};
      dy    = {y[COORD_W-1], y} - {py_pivot[COORD_W-1], py_pivot};
      rot_x = PW'(dx) * PW'(trig_cos) - PW'(dy) * PW'(trig_sin);
      rot_y = PW'(dx) * PW'(trig_sin) + PW'(dy) * PW'(trig_cos);
      qx    = trunc_frac(rot_x);
      qy    = trunc_frac(rot_y);
      case (cfg.mode)
         MODE_TRANSLATE: begin
            wx = WW'(x) + WW'(cfg.param_x);
            wy = WW'(y) + WW'(cfg.param_y);
         end
         MODE_SCALE: begin
            wx = WW'(x) * WW'(cfg.param_x);
            wy = WW'(y) * WW'(cfg.param_y);
         end
         MODE_ROTATE: begin
            wx = WW'(px_pivot) + WW'(qx);
            wy = WW'(py_pivot) + WW'(qy);
         end
         default: begin
            wx = WW'(x);
            wy = WW'(y);
         end
      endcase
      return {sat16(wx), sat16(wy)};
   endfunction

   // All three vertices side by side; the second vertex is the rotation pivot.
   always_comb begin
      {rsp_data_in.out_ax, rsp_data_in.out_ay} =
         vertex(s1_data_ff.ax, s1_data_ff.ay, s1_data_ff.bx, s1_data_ff.by_coord);
      {rsp_data_in.out_bx, rsp_data_in.out_by} =
         vertex(s1_data_ff.bx, s1_data_ff.by_coord, s1_data_ff.bx, s1_data_ff.by_coord);
      {rsp_data_in.out_cx, rsp_data_in.out_cy} =
         vertex(s1_data_ff.cx, s1_data_ff.cy, s1_data_ff.bx, s1_data_ff.by_coord);
   end

`ifndef SYNTHESIS
   // An accepted request always occupies the request register next cycle.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      s1_take |=> s1_valid_ff)
      else $error("accepted request not held");
   // A transfer into the result register makes a result visible.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid_ff)
      else $error("result not presented");
   // Requests are refused only when both registers are full and the output stalls.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request refused without back-pressure");
   // Under rotation the pivot comes out unchanged.
   a_pivot: assert property (@(posedge clock) disable iff (reset)
      (s2_load && cfg.mode == MODE_ROTATE) |=>
      (rsp_data_ff.out_bx == RESULT_W'($past(s1_data_ff.bx)) &&
       rsp_data_ff.out_by == RESULT_W'($past(s1_data_ff.by_coord))))
      else $error("pivot moved under rotation");
`endif

endmodule

// File: hdl/triangle_affine_transform_unit.sv
// Top level of the triangle translate, scale and rotate unit.
//
// Use: a triangle of three 12-bit signed vertices is offered on the req_ch
// channel and taken at a clock edge where valid and ready are both high. One
// result with six saturated 16-bit coordinates leaves on rsp_ch per request.
// The csr_ch channel writes mode (index 0), param_x (1), param_y (2) and
// angle_deg (3); it is always ready and should be used while the unit is idle.
// An accepted request is held in the request register, passes the vertex
// arithmetic and is held in the result register, from which it leaves on
// rsp_ch. Throughput is one request per cycle while rsp_ch does not stall,
// set by the single pass of vertex arithmetic between the two registers.
// Rotation uses a quarter-wave sine table with TRIG_FRAC_BITS
// fraction bits.
// Reset (synchronous, active high) empties both registers and sets every
// configuration register to zero, i.e. translate by nothing. When the result
// receiver stalls, the result is held; one further request is still taken
// into the request register, after which req_ch ready drops until the
// result is read.
module triangle_affine_transform_unit #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   taf_req_if.sink   req_ch,
   taf_rsp_if.source rsp_ch,
   taf_csr_if.sink   csr_ch
);
   import taf_pkg::*;

   taf_cfg_type                      cfg;
   logic signed [TRIG_FRAC_BITS+1:0] trig_sin;
   logic signed [TRIG_FRAC_BITS+1:0] trig_cos;

   // Configuration registers and trig lookup.
   taf_csr_regs #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .cfg      (cfg),
      .trig_sin (trig_sin),
      .trig_cos (trig_cos)
   );

   // Transform pipeline.
   taf_xform #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_xform (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .cfg      (cfg),
      .trig_sin (trig_sin),
      .trig_cos (trig_cos)
   );

endmodule

// File: bench/taf_checker.sv
// Checker for the triangle transform unit: predicts every result and compares it field by field.
module taf_checker #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   taf_req_if          req_ch,
   taf_rsp_if          rsp_ch,
   taf_csr_if          csr_ch,
   output int unsigned mismatch_count,
   output int unsigned outstanding_count,
   output int unsigned checked_count
);
   import taf_pkg::*;

   // Pi with 60 fraction bits, the base of the degree step of the sine table.
   localparam logic [63:0] PI_FRAC60 = 64'h3243F6A8885A308D;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [COORD_W-1:0] param_x;
      logic signed [COORD_W-1:0] param_y;
      logic [ANGLE_W-1:0]        angle;
   } transform_settings_type;

   longint                 quarter_sine [0:90];
   transform_settings_type settings;
   taf_res_type            expected_results [$];
   taf_res_type            oldest;

   // Sine of a whole number of degrees in unsigned Q2.30, by an eleven-term series.
   function automatic logic [63:0] series_sine_q30(input int unsigned degrees);
      logic [63:0] step;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      int unsigned n;
      step = PI_FRAC60 / 64'd180;
      x    = (64'(degrees) * step + (64'd1 << 29)) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n < 11; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // Full-circle sine from the quarter table, angle already within 0 to 359.
   function automatic longint sine_of(input int unsigned a);
      if (a <= 90) return quarter_sine[a];
      if (a <= 180) return quarter_sine[180 - a];
      if (a <= 270) return -quarter_sine[a - 180];
      return -quarter_sine[360 - a];
   endfunction

   // Drops the fraction bits, rounding toward zero.
   function automatic longint drop_fraction(input longint v);
      if (v < 0) return -((-v) >> FRAC_BITS);
      return v >> FRAC_BITS;
   endfunction

   function automatic logic signed [RESULT_W-1:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return RESULT_W'(v);
   endfunction

   // Expected result of one triangle under the given settings.
   function automatic taf_res_type transform_triangle(input taf_tri_type shape,
                                                      input transform_settings_type s);
      longint      vx [3];
      longint      vy [3];
      longint      rx [3];
      longint      ry [3];
      longint      px;
      longint      py;
      longint      sn;
      longint      cs;
      longint      dx;
      longint      dy;
      int unsigned a;
      int unsigned a90;
      taf_res_type r;
      vx[0] = $signed(shape.ax);
      vy[0] = $signed(shape.ay);
      vx[1] = $signed(shape.bx);
      vy[1] = $signed(shape.by_coord);
      vx[2] = $signed(shape.cx);
      vy[2] = $signed(shape.cy);
      px    = $signed(s.param_x);
      py    = $signed(s.param_y);
      a     = s.angle;
      if (a >= 360) a = a - 360;
      a90   = (a + 90 >= 360) ? a + 90 - 360 : a + 90;
      sn    = sine_of(a);
      cs    = sine_of(a90);
      for (int i = 0; i < 3; i++) begin
         case (s.mode)
            MODE_TRANSLATE: begin
               rx[i] = vx[i] + px;
               ry[i] = vy[i] + py;
            end
            MODE_SCALE: begin
               rx[i] = vx[i] * px;
               ry[i] = vy[i] * py;
            end
            MODE_ROTATE: begin
               // Turn about the second vertex.
               dx    = vx[i] - vx[1];
               dy    = vy[i] - vy[1];
               rx[i] = vx[1] + drop_fraction(dx * cs - dy * sn);
               ry[i] = vy[1] + drop_fraction(dx * sn + dy * cs);
            end
            default: begin
               // The spare mode code leaves the triangle as it is.
               rx[i] = vx[i];
               ry[i] = vy[i];
            end
         endcase
      end
      r.out_ax = clamp16(rx[0]);
      r.out_ay = clamp16(ry[0]);
      r.out_bx = clamp16(rx[1]);
      r.out_by = clamp16(ry[1]);
      r.out_cx = clamp16(rx[2]);
      r.out_cy = clamp16(ry[2]);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic signed [RESULT_W-1:0] got,
                                input logic signed [RESULT_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s is %0d, predicted %0d",
                                   checked_count, name, got, want));
      end
   endtask

   // Quarter-wave table rounded to the fraction width of the unit.
   initial begin
      mismatch_count = 0;
      checked_count  = 0;
      for (int k = 0; k <= 90; k++) begin
         quarter_sine[k] = longint'((series_sine_q30(k) + (64'd1 << (29 - FRAC_BITS)))
                                    >> (30 - FRAC_BITS));
      end
   end

   // Track register writes, queue predictions on each request and match results in order.
   always @(posedge clock) begin
      if (reset) begin
         settings = '0;
         expected_results.delete();
         outstanding_count <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_MODE:      settings.mode    = csr_ch.data[1:0];
               CSR_PARAM_X:   settings.param_x = csr_ch.data;
               CSR_PARAM_Y:   settings.param_y = csr_ch.data;
               CSR_ANGLE_DEG: settings.angle   = csr_ch.data[ANGLE_W-1:0];
               default:       ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(transform_triangle(req_ch.data, settings));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               oldest = expected_results.pop_front();
               compare_field("out_ax", rsp_ch.data.out_ax, oldest.out_ax);
               compare_field("out_ay", rsp_ch.data.out_ay, oldest.out_ay);
               compare_field("out_bx", rsp_ch.data.out_bx, oldest.out_bx);
               compare_field("out_by", rsp_ch.data.out_by, oldest.out_by);
               compare_field("out_cx", rsp_ch.data.out_cx, oldest.out_cx);
               compare_field("out_cy", rsp_ch.data.out_cy, oldest.out_cy);
               checked_count++;
            end
         end
         outstanding_count <= expected_results.size();
      end
   end

endmodule

// File: bench/tb_top.sv
// Testbench top for the triangle transform unit: clock, reset, stimulus and the verdict.
module tb_top;
   import taf_pkg::*;

   // Mode code that the unit does not define; triangles should pass unchanged.
   localparam logic [1:0] MODE_UNUSED      = 2'd3;
   localparam int         TRIANGLE_TARGET  = 1650;
   localparam int         LONG_HOLD_CYCLES = 80;
   localparam int         DRAIN_CYCLES     = 10;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [COORD_W-1:0] param_x;
      logic signed [COORD_W-1:0] param_y;
      logic [ANGLE_W-1:0]        angle;
   } transform_cfg_type;

   logic        clock;
   logic        reset;
   bit          steady_flow;
   int unsigned rsp_hold_cycles;
   int unsigned triangles_sent;
   int unsigned rotated_sent;
   int unsigned settings_used;
   int unsigned corner_index;
   logic [1:0]  active_mode;
   int unsigned mismatch_count;
   int unsigned outstanding_count;
   int unsigned checked_count;

   taf_req_if req_ch ();
   taf_rsp_if rsp_ch ();
   taf_csr_if csr_ch ();

   triangle_affine_transform_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   taf_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count),
      .checked_count     (checked_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("run timed out with %0d results outstanding", outstanding_count);
      $display("status: fail");
      $finish;
   end

   function automatic transform_cfg_type cfg_of(input logic [1:0] mode,
                                               input logic signed [COORD_W-1:0] px,
                                               input logic signed [COORD_W-1:0] py,
                                               input logic [ANGLE_W-1:0] angle);
      transform_cfg_type c;
      c.mode    = mode;
      c.param_x = px;
      c.param_y = py;
      c.angle   = angle;
      return c;
   endfunction

   // Coordinate biased toward the two ends of the range.
   function automatic logic signed [COORD_W-1:0] pick_coord();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return -12'sd2048;
      if (r == 1) return 12'sd2047;
      return COORD_W'($urandom_range(0, 4095));
   endfunction

   // Offset or factor: ends of the range, small values, or anything.
   function automatic logic signed [COORD_W-1:0] pick_param();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return -12'sd2048;
      if (r == 1) return 12'sd2047;
      if (r == 2) return COORD_W'($urandom_range(0, 8) - 4);
      return COORD_W'($urandom_range(0, 4095));
   endfunction

   function automatic taf_tri_type random_triangle();
      taf_tri_type t;
      t.ax       = pick_coord();
      t.ay       = pick_coord();
      t.bx       = pick_coord();
      t.by_coord = pick_coord();
      t.cx       = pick_coord();
      t.cy       = pick_coord();
      return t;
   endfunction

   // Fixed triangles at the corners and near the centre of the coordinate range.
   function automatic taf_tri_type corner_triangle(input int unsigned k);
      case (k % 4)
         0:       return {12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047, -12'sd2048};
         1:       return {6{12'sd2047}};
         2:       return {6{-12'sd2048}};
         default: return {-12'sd2048, 12'sd2047, 12'sd0, 12'sd0, -12'sd1, 12'sd1};
      endcase
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   task automatic send_triangle(input taf_tri_type shape);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.data  = shape;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      triangles_sent++;
      if (active_mode == MODE_ROTATE) rotated_sent++;
   endtask

   // Holds back new requests until every predicted result has been received.
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (outstanding_count != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] value);
      csr_ch.index = index;
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // Writes all four registers once the unit has gone idle.
   task automatic apply_settings(input transform_cfg_type c);
      wait_drained();
      csr_write(CSR_MODE, CSR_DAT_W'(c.mode));
      csr_write(CSR_PARAM_X, c.param_x);
      csr_write(CSR_PARAM_Y, c.param_y);
      csr_write(CSR_ANGLE_DEG, CSR_DAT_W'(c.angle));
      csr_ch.valid = 1'b0;
      active_mode  = c.mode;
      settings_used++;
   endtask

   task automatic run_corners(input transform_cfg_type c, input int unsigned count);
      apply_settings(c);
      repeat (count) begin
         send_triangle(corner_triangle(corner_index));
         corner_index++;
      end
   endtask

   // Result receiver: random stalls per result, and a long hold-off when asked.
   initial begin : result_receiver
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = steady_flow ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Request and register stimulus, then the verdict.
   initial begin : stimulus
      transform_cfg_type c;
      int unsigned       r;
      int unsigned       count;
      int unsigned       phase;
      reset           = 1'b1;
      steady_flow     = 1'b0;
      rsp_hold_cycles = 0;
      triangles_sent  = 0;
      rotated_sent    = 0;
      settings_used   = 0;
      corner_index    = 0;
      active_mode     = MODE_TRANSLATE;
      req_ch.valid    = 1'b0;
      req_ch.data     = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_MODE;
      csr_ch.data     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reset settings first, then every mode at its extremes.
      repeat (2) begin
         send_triangle(corner_triangle(corner_index));
         corner_index++;
      end
      run_corners(cfg_of(MODE_TRANSLATE, 12'sd2047, -12'sd2048, 9'd0), 2);
      run_corners(cfg_of(MODE_SCALE, -12'sd2048, 12'sd2047, 9'd0), 3);
      run_corners(cfg_of(MODE_SCALE, 12'sd0, -12'sd1, 9'd0), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd90), 2);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd0), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd180), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd270), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd359), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd45), 1);
      // Angles past a full turn are taken modulo 360.
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd400), 1);
      run_corners(cfg_of(MODE_ROTATE, 12'sd0, 12'sd0, 9'd511), 1);
      run_corners(cfg_of(MODE_UNUSED, 12'sd1000, -12'sd1000, 9'd123), 2);

      // Random part: random settings per phase, random triangles within it.
      phase = 0;
      while (triangles_sent < TRIANGLE_TARGET) begin
         r = $urandom_range(0, 9);
         c.mode    = (r < 3) ? MODE_TRANSLATE : (r < 6) ? MODE_SCALE :
                     (r < 9) ? MODE_ROTATE : MODE_UNUSED;
         c.param_x = pick_param();
         c.param_y = pick_param();
         r = $urandom_range(0, 9);
         c.angle   = (r == 0) ? ANGLE_W'($urandom_range(360, 511)) :
                     (r == 1) ? ANGLE_W'($urandom_range(0, 1) * 359) :
                                ANGLE_W'($urandom_range(0, 359));
         apply_settings(c);
         steady_flow = ($urandom_range(0, 3) == 0);
         count = $urandom_range(20, 90);
         if (phase == 2) begin
            // Back-to-back requests against a stalled receiver fill the unit.
            steady_flow     = 1'b1;
            rsp_hold_cycles = LONG_HOLD_CYCLES;
         end
         for (int j = 0; j < count; j++) begin
            send_triangle(random_triangle());
            if (phase == 4 && j == count / 2) wait_drained();
         end
         phase++;
      end

      steady_flow = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d triangles (%0d rotated) under %0d register settings; %0d results checked",
               triangles_sent, rotated_sent, settings_used, checked_count);
      $display("covered all four mode codes, angles beyond 359, saturation and a long result stall");
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
